/* design/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg
// Operator codes, status codes and character constants for the evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam logic [2:0] OP_OPEN = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIVZERO   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } out_beat_t;

    function automatic logic high_prec(input logic [2:0] code);
        return (code == OP_MUL) || (code == OP_DIV);
    endfunction

endpackage

/* design/iee_in_if.sv */
// ----------------------------------------------------------------------------
// iee_in_if
// Character channel: valid/ready with symbol and last.
// ----------------------------------------------------------------------------
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

/* design/iee_out_if.sv */
// ----------------------------------------------------------------------------
// iee_out_if
// Result channel: valid/ready with value and status.
// ----------------------------------------------------------------------------
interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

/* design/infix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Two-stack infix evaluator over synchronous stack memories.
// ----------------------------------------------------------------------------
// Each reduction reads the top operator and both operands, then writes back;
// a division waits for the divider. One character at a time; ready is high
// only in the idle state. The result register frees the core once loaded.
// Reset clears counts, status and control; stack memories are not cleared.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core #(
    parameter int NUMBER_DEPTH   = 16,
    parameter int OPERATOR_DEPTH = 16,
    parameter int VALUE_WIDTH    = 32
) (
    input logic   clk,
    input logic   rst_n,
    iee_in_if.sink    in_ch,
    iee_out_if.source out_ch
);

    localparam int NAW = $clog2(NUMBER_DEPTH);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int NCW = $clog2(NUMBER_DEPTH + 1);
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_OPRD  = 4'd2;
    localparam logic [3:0] S_OPCK  = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]             state_reg;
    logic [7:0]             sym_reg;
    logic                   last_reg;
    logic [2:0]             code_reg;
    logic                   mode_close_reg;
    logic                   fin_reg;
    logic [NCW-1:0]         ncnt_reg;
    logic [OCW-1:0]         ocnt_reg;
    logic [1:0]             sticky_reg;
    logic [2:0]             top_op_reg;
    logic [VALUE_WIDTH-1:0] b_reg;
    logic [VALUE_WIDTH-1:0] a_reg;

    logic [VALUE_WIDTH-1:0] nmem [NUMBER_DEPTH];
    logic [2:0]             omem [OPERATOR_DEPTH];
    logic [VALUE_WIDTH-1:0] nrd_reg;
    logic [2:0]             ord_reg;

    logic                   nwe;
    logic [NAW-1:0]         nwa;
    logic [VALUE_WIDTH-1:0] nwd;
    logic [NAW-1:0]         nra;
    logic                   owe;
    logic [OAW-1:0]         owa;
    logic [2:0]             owd;
    logic [OAW-1:0]         ora;

    logic                   out_valid_reg;
    logic signed [31:0]     out_value_reg;
    logic [1:0]             out_status_reg;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_q;

    logic [3:0]             state_next;
    logic [NCW-1:0]         ncnt_next;
    logic [OCW-1:0]         ocnt_next;
    logic [1:0]             sticky_next;
    logic                   fin_next;
    logic                   mode_close_next;
    logic [2:0]             code_next;
    logic                   load_out;
    logic [VALUE_WIDTH-1:0] alu;
    logic                   is_digit;

    iee_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.value  = out_value_reg;
    assign out_ch.status = out_status_reg;
    assign is_digit = (sym_reg >= iee_pkg::CH_ZERO) && (sym_reg <= iee_pkg::CH_NINE);

    always_ff @(posedge clk)
    begin
        if (nwe)
            nmem[nwa] <= nwd;
        nrd_reg <= nmem[nra];
        if (owe)
            omem[owa] <= owd;
        ord_reg <= omem[ora];
    end

    always_comb
    begin
        unique case (top_op_reg)
            iee_pkg::OP_ADD: alu = a_reg + b_reg;
            iee_pkg::OP_SUB: alu = a_reg - b_reg;
            default:         alu = a_reg * b_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        ncnt_next       = ncnt_reg;
        ocnt_next       = ocnt_reg;
        sticky_next     = sticky_reg;
        fin_next        = fin_reg;
        mode_close_next = mode_close_reg;
        code_next       = code_reg;
        nwe = 1'b0;
        nwa = ncnt_reg[NAW-1:0];
        nwd = '0;
        nra = '0;
        owe = 1'b0;
        owa = ocnt_reg[OAW-1:0];
        owd = '0;
        ora = OAW'(ocnt_reg - 1'b1);
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                fin_next = 1'b0;
                state_next = last_reg ? S_FIN : S_IDLE;
                if (sticky_reg == iee_pkg::ST_OK)
                begin
                    if (is_digit)
                    begin
                        if (ncnt_reg >= NCW'(NUMBER_DEPTH))
                            sticky_next = iee_pkg::ST_OVERFLOW;
                        else
                        begin
                            nwe = 1'b1;
                            nwd = VALUE_WIDTH'(sym_reg - iee_pkg::CH_ZERO);
                            ncnt_next = ncnt_reg + 1'b1;
                        end
                    end
                    else if (sym_reg == iee_pkg::CH_OPEN)
                    begin
                        if (ocnt_reg >= OCW'(OPERATOR_DEPTH))
                            sticky_next = iee_pkg::ST_OVERFLOW;
                        else
                        begin
                            owe = 1'b1;
                            owd = iee_pkg::OP_OPEN;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                    end
                    else if (sym_reg == iee_pkg::CH_CLOSE || sym_reg == iee_pkg::CH_ADD
                             || sym_reg == iee_pkg::CH_SUB || sym_reg == iee_pkg::CH_MUL
                             || sym_reg == iee_pkg::CH_DIV)
                    begin
                        mode_close_next = (sym_reg == iee_pkg::CH_CLOSE);
                        case (sym_reg)
                            iee_pkg::CH_ADD: code_next = iee_pkg::OP_ADD;
                            iee_pkg::CH_SUB: code_next = iee_pkg::OP_SUB;
                            iee_pkg::CH_MUL: code_next = iee_pkg::OP_MUL;
                            default:         code_next = iee_pkg::OP_DIV;
                        endcase
                        state_next = S_OPRD;
                    end
                end
            end
            S_OPRD:
            begin
                state_next = S_OPCK;
            end
            S_OPCK:
            begin
                // ord_reg holds the top operator when ocnt_reg > 0
                if (sticky_reg != iee_pkg::ST_OK)
                    state_next = fin_reg ? S_FRD : (last_reg ? S_FIN : S_IDLE);
                else if (fin_reg)
                begin
                    if (ocnt_reg == '0)
                        state_next = S_FRD;
                    else
                        state_next = S_RDB;
                end
                else if (mode_close_reg)
                begin
                    if (ocnt_reg == '0)
                    begin
                        sticky_next = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else if (ord_reg == iee_pkg::OP_OPEN)
                    begin
                        ocnt_next = ocnt_reg - 1'b1;
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else
                        state_next = S_RDB;
                end
                else
                begin
                    if (ocnt_reg != '0 && ord_reg != iee_pkg::OP_OPEN
                        && (iee_pkg::high_prec(ord_reg) || !iee_pkg::high_prec(code_reg)))
                        state_next = S_RDB;
                    else if (ocnt_reg >= OCW'(OPERATOR_DEPTH))
                    begin
                        sticky_next = iee_pkg::ST_OVERFLOW;
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        owe = 1'b1;
                        owd = code_reg;
                        ocnt_next = ocnt_reg + 1'b1;
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                end
                if (state_next == S_RDB)
                begin
                    ocnt_next = ocnt_reg - 1'b1;
                    if (ord_reg == iee_pkg::OP_OPEN || ncnt_reg < NCW'(2))
                    begin
                        sticky_next = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else
                        nra = NAW'(ncnt_reg - 1'b1);
                end
            end
            S_RDB:
            begin
                nra = NAW'(ncnt_reg - NCW'(2));
                state_next = S_RDA;
            end
            S_RDA:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (top_op_reg == iee_pkg::OP_DIV)
                begin
                    if (b_reg == '0)
                    begin
                        sticky_next = iee_pkg::ST_DIVZERO;
                        ncnt_next = ncnt_reg - NCW'(2);
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        state_next = S_DIVW;
                    end
                end
                else
                begin
                    nwe = 1'b1;
                    nwa = NAW'(ncnt_reg - NCW'(2));
                    nwd = alu;
                    ncnt_next = ncnt_reg - 1'b1;
                    state_next = S_OPRD;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    nwe = 1'b1;
                    nwa = NAW'(ncnt_reg - NCW'(2));
                    nwd = div_q;
                    ncnt_next = ncnt_reg - 1'b1;
                    state_next = S_OPRD;
                end
            end
            S_FIN:
            begin
                fin_next = 1'b1;
                state_next = S_OPRD;
            end
            S_FRD:
            begin
                if (sticky_reg == iee_pkg::ST_OK && ncnt_reg != NCW'(1))
                    sticky_next = iee_pkg::ST_MALFORMED;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out = 1'b1;
                    ncnt_next = '0;
                    ocnt_next = '0;
                    sticky_next = iee_pkg::ST_OK;
                    fin_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ncnt_reg       <= '0;
            ocnt_reg       <= '0;
            sticky_reg     <= iee_pkg::ST_OK;
            fin_reg        <= 1'b0;
            mode_close_reg <= 1'b0;
            code_reg       <= iee_pkg::OP_ADD;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ncnt_reg       <= ncnt_next;
            ocnt_reg       <= ocnt_next;
            sticky_reg     <= sticky_next;
            fin_reg        <= fin_next;
            mode_close_reg <= mode_close_next;
            code_reg       <= code_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            sym_reg  <= in_ch.symbol;
            last_reg <= in_ch.last;
        end
        if (state_reg == S_OPCK)
            top_op_reg <= ord_reg;
        if (state_reg == S_RDB)
            b_reg <= nrd_reg;
        if (state_reg == S_RDA)
            a_reg <= nrd_reg;
        if (load_out)
        begin
            out_status_reg <= sticky_reg;
            out_value_reg  <= (sticky_reg == iee_pkg::ST_OK)
                ? 32'(signed'(nrd_reg)) : 32'sd0;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ncnt_reg <= NCW'(NUMBER_DEPTH) && ocnt_reg <= OCW'(OPERATOR_DEPTH))
        else $error("stack count out of range");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == S_DISP)
        else $error("accepted beat not dispatched");

    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (ncnt_reg == '0 && ocnt_reg == '0 && sticky_reg == iee_pkg::ST_OK))
        else $error("state not cleared after result");

endmodule

/* design/iee_divider.sv */
// ----------------------------------------------------------------------------
// iee_divider
// Signed restoring divider, one quotient bit per cycle, truncating toward 0.
// ----------------------------------------------------------------------------
module iee_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] div_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   shifted;

    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign done    = busy_reg && (cnt_reg == '0);
    assign quotient = neg_reg ? (VALUE_WIDTH'(0) - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(VALUE_WIDTH);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - dividend) : dividend;
            div_reg <= divisor[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - divisor) : divisor;
            neg_reg <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (!trial[VALUE_WIDTH])
                rem_reg <= trial[VALUE_WIDTH-1:0];
            else
                rem_reg <= shifted[VALUE_WIDTH-1:0];
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
        end
    end

endmodule
